// File: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Character codes, escape modes, output group type and hex helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // escape modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;

    // output group sizing
    localparam int GRP_MAX = 5;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;

    // group queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // held hex digits
    localparam int HELD_DEPTH = 3;

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // UTF-8 encoding constants
    localparam logic [15:0] UTF_1B_LIMIT = 16'h0080;
    localparam logic [15:0] UTF_2B_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2    = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3    = 8'hE0;
    localparam logic [7:0]  UTF_CONT     = 8'h80;

    // one group of result bytes caused by one input byte
    typedef struct packed {
        logic [GRP_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    last;
    } grp_t;

    function automatic logic is_hex(input logic [7:0] b);
        logic res;
        res = ((b >= 8'h30) && (b <= 8'h39)) ||
              ((b >= 8'h41) && (b <= 8'h46)) ||
              ((b >= 8'h61) && (b <= 8'h66));
        return res;
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] b);
        logic [3:0] res;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            res = b[3:0];
        end else begin
            // 'A'..'F' and 'a'..'f' share the low nibble 1..6
            res = b[3:0] + 4'd9;
        end
        return res;
    endfunction

endpackage

// File: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Accepts raw bytes, tracks escape state and held hex digits, and builds the
// group of result bytes that each byte causes.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          push,
    output jsu_pkg::grp_t grp
);

    logic [1:0] mode_reg, mode_next;
    logic [1:0] hc_reg, hc_next;
    logic [7:0] held_reg [jsu_pkg::HELD_DEPTH];
    logic       wr_held;
    logic       b_hex;
    logic       b_bs;
    logic       tail;
    logic [15:0] cp;

    assign b_hex = jsu_pkg::is_hex(in_byte);
    assign b_bs  = (in_byte == jsu_pkg::CH_BSLASH);
    assign cp    = {jsu_pkg::hex_nib(held_reg[0]), jsu_pkg::hex_nib(held_reg[1]),
                    jsu_pkg::hex_nib(held_reg[2]), jsu_pkg::hex_nib(in_byte)};

    // decode one byte into a result group and the next state
    always_comb begin
        mode_next = mode_reg;
        hc_next   = hc_reg;
        wr_held   = 1'b0;
        tail      = 1'b0;
        grp.last  = in_last;
        grp.cnt   = '0;
        grp.bytes = '0;
        case (mode_reg)
            jsu_pkg::MODE_ESC: begin
                mode_next    = jsu_pkg::MODE_PLAIN;
                grp.cnt      = jsu_pkg::CNT_W'(1);
                grp.bytes[0] = in_byte;
                case (in_byte)
                    jsu_pkg::CH_N: grp.bytes[0] = jsu_pkg::CH_LF;
                    jsu_pkg::CH_T: grp.bytes[0] = jsu_pkg::CH_TAB;
                    jsu_pkg::CH_R: grp.bytes[0] = jsu_pkg::CH_CR;
                    jsu_pkg::CH_U: begin
                        if (in_last) begin
                            grp.bytes[0] = jsu_pkg::CH_QMARK;
                        end else begin
                            mode_next = jsu_pkg::MODE_HEX;
                            hc_next   = 2'd0;
                            grp.cnt   = '0;
                        end
                    end
                    default: grp.bytes[0] = in_byte;
                endcase
            end
            jsu_pkg::MODE_HEX: begin
                // replay layout: '?', held digits, then the byte itself
                grp.bytes[0] = jsu_pkg::CH_QMARK;
                grp.bytes[1] = (hc_reg > 2'd0) ? held_reg[0] : in_byte;
                grp.bytes[2] = (hc_reg > 2'd1) ? held_reg[1] : in_byte;
                grp.bytes[3] = (hc_reg > 2'd2) ? held_reg[2] : in_byte;
                grp.bytes[4] = in_byte;
                if (!b_hex) begin
                    // short hex run broken by a non-hex byte
                    tail      = !(b_bs && !in_last);
                    mode_next = tail ? jsu_pkg::MODE_PLAIN : jsu_pkg::MODE_ESC;
                    hc_next   = 2'd0;
                    grp.cnt   = {1'b0, hc_reg} + 3'd1 + {2'b00, tail};
                end else if (hc_reg == 2'd3) begin
                    // fourth digit: encode code point as UTF-8
                    mode_next = jsu_pkg::MODE_PLAIN;
                    hc_next   = 2'd0;
                    if (cp < jsu_pkg::UTF_1B_LIMIT) begin
                        grp.cnt      = 3'd1;
                        grp.bytes[0] = cp[7:0];
                    end else if (cp < jsu_pkg::UTF_2B_LIMIT) begin
                        grp.cnt      = 3'd2;
                        grp.bytes[0] = jsu_pkg::UTF_LEAD2 | {3'b000, cp[10:6]};
                        grp.bytes[1] = jsu_pkg::UTF_CONT | {2'b00, cp[5:0]};
                    end else begin
                        grp.cnt      = 3'd3;
                        grp.bytes[0] = jsu_pkg::UTF_LEAD3 | {4'b0000, cp[15:12]};
                        grp.bytes[1] = jsu_pkg::UTF_CONT | {2'b00, cp[11:6]};
                        grp.bytes[2] = jsu_pkg::UTF_CONT | {2'b00, cp[5:0]};
                    end
                end else if (in_last) begin
                    // string ends inside the hex run
                    mode_next = jsu_pkg::MODE_PLAIN;
                    hc_next   = 2'd0;
                    grp.cnt   = {1'b0, hc_reg} + 3'd2;
                end else begin
                    wr_held = 1'b1;
                    hc_next = hc_reg + 2'd1;
                end
            end
            default: begin
                // plain text
                if (b_bs && !in_last) begin
                    mode_next = jsu_pkg::MODE_ESC;
                end else begin
                    grp.cnt      = 3'd1;
                    grp.bytes[0] = in_byte;
                end
            end
        endcase
        if (in_last) begin
            mode_next = jsu_pkg::MODE_PLAIN;
            hc_next   = 2'd0;
        end
    end

    assign push = accept && (grp.cnt != '0);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= jsu_pkg::MODE_PLAIN;
            hc_reg   <= 2'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            hc_reg   <= hc_next;
        end
    end

    // held hex digits, no reset
    always_ff @(posedge aclk) begin
        if (accept && wr_held) begin
            held_reg[hc_reg] <= in_byte;
        end
    end

endmodule

// File: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: result group FIFO
// Short queue of result groups between the decoder and the output serializer.
// ----------------------------------------------------------------------------
module jsu_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jsu_pkg::grp_t push_grp,
    input  logic          pop,
    output logic          full,
    output logic          q_valid,
    output jsu_pkg::grp_t q_grp
);

    jsu_pkg::grp_t mem_reg [jsu_pkg::QDEPTH];
    logic [jsu_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_grp   = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("group queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("group queue underflow");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH))
        else $error("group queue count out of range");

    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_grp.cnt != '0 && push_grp.cnt <= jsu_pkg::CNT_W'(jsu_pkg::GRP_MAX)))
        else $error("bad group size pushed");

endmodule

// File: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: output serializer
// Takes result groups from the queue and sends their bytes one per cycle,
// while the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  jsu_pkg::grp_t q_grp,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_out_last
);

    jsu_pkg::grp_t               cur_reg;
    logic                        cur_valid_reg, cur_valid_next;
    logic [jsu_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  m_byte_reg;
    logic                        m_last_reg;
    logic                        adv;
    logic                        cur_end;

    // advance when a group is loaded and the output stage is free
    assign adv     = cur_valid_reg && (!m_valid_reg || m_ready);
    assign cur_end = (idx_reg == (cur_reg.cnt - 3'd1));
    assign pop     = q_valid && (!cur_valid_reg || (adv && cur_end));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (adv) begin
            cur_valid_next = !cur_end;
            idx_next       = idx_reg + 1'b1;
        end
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_grp;
        end
        if (adv) begin
            m_byte_reg <= cur_reg.bytes[idx_reg];
            m_last_reg <= cur_reg.last && cur_end;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (idx_reg < cur_reg.cnt))
        else $error("serializer index past end of group");

endmodule

// File: design/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top: JSON string body unescaper
// Decodes escapes and \u sequences (to UTF-8) of a quoted string body.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------
//  s_       | in        | s_valid / s_ready  | s_in_byte, s_in_last
//  m_       | out       | m_valid / m_ready  | m_out_byte, m_out_last
//
//  One input byte is accepted per cycle while the 4-entry group queue has room.
//  Each byte yields 0..5 output bytes, sent by the serializer one per cycle
//  while m_ready is high; the output port sets the sustained rate.
//  A result passes the group queue, the current-group register and the output register.
//  Synchronous active-low reset clears escape state, queue and output valid.
//  Input and output stall independently; the queue absorbs output bursts.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          full;
    logic          q_valid;
    jsu_pkg::grp_t push_grp;
    jsu_pkg::grp_t q_grp;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    jsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push),
        .grp     (push_grp)
    );

    jsu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .full     (full),
        .q_valid  (q_valid),
        .q_grp    (q_grp)
    );

    jsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_grp      (q_grp),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule
